@@ hw/rtl/gslm_pkg.sv @@
// Package for the gated sound level meter: widths, register indexes and reset values.
package gslm_pkg;

	localparam int SAMPLE_BITS_DEF       = 12;
	localparam int WINDOW_COUNT_BITS_DEF = 20;

	localparam int GATE_W     = 12;
	localparam int LEN_W      = 8;
	localparam int ALERT_W    = 12;
	localparam int GAIN_W     = 16;
	localparam int OFFSET_W   = 20;
	localparam int LEVEL_W    = 12;
	localparam int COUNT_W    = 8;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_ADDR_W = 3;
	localparam int FRAC_W     = 16;
	localparam int MUL_W      = 32;

	typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

	localparam cfg_addr_t REG_GATE_THRESHOLD = 3'd0;
	localparam cfg_addr_t REG_WINDOW_LENGTH  = 3'd1;
	localparam cfg_addr_t REG_ALERT_LEVEL    = 3'd2;
	localparam cfg_addr_t REG_LOG_GAIN       = 3'd3;
	localparam cfg_addr_t REG_LEVEL_OFFSET   = 3'd4;

	localparam logic [GATE_W-1:0]   GATE_RESET   = 12'd1350;
	localparam logic [LEN_W-1:0]    LENGTH_RESET = 8'd100;
	localparam logic [ALERT_W-1:0]  ALERT_RESET  = 12'd1120;
	localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd24745;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 20'd168315;

	// ln 2 in Q.16
	localparam logic [MUL_W-1:0] LN2_Q16 = 32'd45426;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 12'd4095;

endpackage

@@ hw/rtl/gated_sound_level_meter_top.sv @@
// Gated sound level meter: windowed gated mean, log level and running average.
//
//  channel   handshake              payload
//  in        in_valid / in_ready    sample
//  out       out_valid / out_ready  current_level, average_level, samples_used,
//                                   no_signal, alert
//  cfg       cfg_we                 cfg_addr, cfg_wdata
//
// A sample that does not close a window is taken in ST_IDLE. A sample that
// closes a window with gated samples runs, in order: a one-bit-per-cycle
// restoring divider for the mean (SAMPLE_BITS+16 steps), a leading-one search,
// sixteen squarings on one shared 32x32 multiplier (a multiply state and an
// update state each), two more products, and twelve steps of the same divider
// for the running average. An empty window skips all of this and goes straight
// to ST_EMIT. Reset is asynchronous and needs no clearing pass. A waiting result
// blocks only the next window close.
module gated_sound_level_meter_top #(
	parameter int SAMPLE_BITS       = gslm_pkg::SAMPLE_BITS_DEF,
	parameter int WINDOW_COUNT_BITS = gslm_pkg::WINDOW_COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [SAMPLE_BITS-1:0]          sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [gslm_pkg::LEVEL_W-1:0]    current_level,
	output logic [gslm_pkg::LEVEL_W-1:0]    average_level,
	output logic [gslm_pkg::COUNT_W-1:0]    samples_used,
	output logic                            no_signal,
	output logic                            alert,
	input  logic                            cfg_we,
	input  gslm_pkg::cfg_addr_t             cfg_addr,
	input  logic [gslm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import gslm_pkg::*;

	localparam int SUM_W = SAMPLE_BITS + COUNT_W;
	localparam int QW    = SAMPLE_BITS + FRAC_W;
	localparam int RW    = WINDOW_COUNT_BITS;
	localparam int TW    = LEVEL_W + WINDOW_COUNT_BITS;
	localparam int CW    = (SAMPLE_BITS > GATE_W) ? SAMPLE_BITS : GATE_W;
	localparam int CNT_W = $clog2(QW + 1);
	localparam int PROD_W = 2 * MUL_W;
	localparam int LV_W  = 52;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_DIV      = 4'd1;
	localparam logic [3:0] ST_NORM     = 4'd2;
	localparam logic [3:0] ST_SQ_MUL   = 4'd3;
	localparam logic [3:0] ST_SQ_UPD   = 4'd4;
	localparam logic [3:0] ST_MUL_K    = 4'd5;
	localparam logic [3:0] ST_MUL_P    = 4'd6;
	localparam logic [3:0] ST_LEVEL    = 4'd7;
	localparam logic [3:0] ST_AVG_LOAD = 4'd8;
	localparam logic [3:0] ST_AVG_DIV  = 4'd9;
	localparam logic [3:0] ST_EMIT     = 4'd10;

	logic [3:0]             state_q;

	logic [GATE_W-1:0]      gate_q;
	logic [LEN_W-1:0]       length_q;
	logic [ALERT_W-1:0]     alert_level_q;
	logic [GAIN_W-1:0]      gain_q;
	logic [OFFSET_W-1:0]    offset_q;

	logic [SUM_W-1:0]       sum_q;
	logic [COUNT_W-1:0]     count_q;
	logic [LEN_W-1:0]       pos_q;
	logic [TW-1:0]          total_q;
	logic [RW-1:0]          windows_q;

	logic [RW-1:0]          rem_q;
	logic [QW-1:0]          div_sh_q;
	logic [RW-1:0]          divisor_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [MUL_W-1:0]       m_q;
	logic [4:0]             p_q;
	logic [FRAC_W-1:0]      frac_q;
	logic [PROD_W-1:0]      prod_q;
	logic [LEVEL_W-1:0]     level_q;
	logic [LEVEL_W-1:0]     avg_q;
	logic [COUNT_W-1:0]     used_q;
	logic                   empty_q;

	logic                   out_valid_q;
	logic [LEVEL_W-1:0]     cur_out_q;
	logic [LEVEL_W-1:0]     avg_out_q;
	logic [COUNT_W-1:0]     used_out_q;
	logic                   no_signal_q;
	logic                   alert_q;

	// gated accumulation
	logic [CW-1:0]          s_ext;
	logic [CW-1:0]          gate_eff;
	logic                   pass;
	logic [SUM_W-1:0]       sum_next;
	logic [COUNT_W-1:0]     count_next;
	logic [LEN_W:0]         pos_next;
	logic [LEN_W:0]         len_eff;
	logic                   win_end;
	logic                   in_xfer;

	// shared divider step
	logic [RW:0]            trial;
	logic                   ge;
	logic [RW:0]            trial_diff;
	logic [RW-1:0]          rem_next;

	// shared multiplier
	logic [MUL_W-1:0]       mul_a;
	logic [MUL_W-1:0]       mul_b;
	logic [PROD_W-1:0]      mul_p;

	// squaring step
	logic [MUL_W:0]         sq_t;

	// level
	logic [LV_W-1:0]        lv_p;
	logic [LV_W-1:0]        lv_o;
	logic [LV_W:0]          lv_d;
	logic [LV_W-36:0]       lv_raw;
	logic [LEVEL_W-1:0]     lv_sat;

	// average numerator
	logic [TW-1:0]          avg_num;

	logic                   out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;

	assign s_ext    = CW'(sample);
	assign gate_eff = CW'(gate_q) & CW'({SAMPLE_BITS{1'b1}});
	assign pass     = s_ext > gate_eff;

	assign sum_next   = pass ? (sum_q + SUM_W'(sample)) : sum_q;
	assign count_next = pass ? (count_q + COUNT_W'(1)) : count_q;
	assign pos_next   = {1'b0, pos_q} + (LEN_W+1)'(1);
	assign len_eff    = (length_q == '0) ? (LEN_W+1)'(1) : {1'b0, length_q};
	assign win_end    = pos_next >= len_eff;

	assign trial      = {rem_q, div_sh_q[QW-1]};
	assign trial_diff = trial - {1'b0, divisor_q};
	assign ge         = trial >= {1'b0, divisor_q};
	assign rem_next   = ge ? trial_diff[RW-1:0] : trial[RW-1:0];

	always_comb begin
		unique case (state_q)
			ST_SQ_MUL: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			ST_MUL_K: begin
				mul_a = MUL_W'(gain_q);
				mul_b = LN2_Q16;
			end
			ST_MUL_P: begin
				mul_a = prod_q[MUL_W-1:0];
				mul_b = MUL_W'({p_q[3:0], frac_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	assign sq_t = prod_q[PROD_W-1:MUL_W-1];

	// level = (gain*ln - offset + 2^35) >> 36, rounded half up
	assign lv_p   = prod_q[LV_W-1:0];
	assign lv_o   = {offset_q, {MUL_W{1'b0}}};
	assign lv_d   = {1'b0, lv_p} - {1'b0, lv_o} + (LV_W+1)'(64'h8_0000_0000);
	assign lv_raw = lv_d[LV_W:36];
	assign lv_sat = (lv_p <= lv_o) ? '0 :
		((lv_raw > (LV_W-35)'(LEVEL_MAX)) ? LEVEL_MAX : lv_raw[LEVEL_W-1:0]);

	assign avg_num = total_q + TW'(windows_q >> 1);

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			gate_q        <= GATE_RESET;
			length_q      <= LENGTH_RESET;
			alert_level_q <= ALERT_RESET;
			gain_q        <= GAIN_RESET;
			offset_q      <= OFFSET_RESET;
			sum_q         <= '0;
			count_q       <= '0;
			pos_q         <= '0;
			total_q       <= '0;
			windows_q     <= '0;
			rem_q         <= '0;
			div_sh_q      <= '0;
			divisor_q     <= '0;
			cnt_q         <= '0;
			m_q           <= '0;
			p_q           <= '0;
			frac_q        <= '0;
			prod_q        <= '0;
			level_q       <= '0;
			avg_q         <= '0;
			used_q        <= '0;
			empty_q       <= 1'b0;
			out_valid_q   <= 1'b0;
			cur_out_q     <= '0;
			avg_out_q     <= '0;
			used_out_q    <= '0;
			no_signal_q   <= 1'b0;
			alert_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_GATE_THRESHOLD: gate_q        <= cfg_wdata[GATE_W-1:0];
					REG_WINDOW_LENGTH:  length_q      <= cfg_wdata[LEN_W-1:0];
					REG_ALERT_LEVEL:    alert_level_q <= cfg_wdata[ALERT_W-1:0];
					REG_LOG_GAIN:       gain_q        <= cfg_wdata[GAIN_W-1:0];
					REG_LEVEL_OFFSET:   offset_q      <= cfg_wdata[OFFSET_W-1:0];
					default: ;
				endcase
			end

			// load a new result, or drop the old one once it is taken
			if (state_q == ST_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (win_end) begin
							sum_q     <= '0;
							count_q   <= '0;
							pos_q     <= '0;
							used_q    <= count_next;
							// mean = sum * 2^16 / count; high quotient bits are zero
							rem_q     <= RW'(sum_next[SUM_W-1:SAMPLE_BITS]);
							div_sh_q  <= {sum_next[SAMPLE_BITS-1:0], {FRAC_W{1'b0}}};
							divisor_q <= RW'(count_next);
							cnt_q     <= CNT_W'(QW);
							if (count_next == '0) begin
								empty_q <= 1'b1;
								level_q <= '0;
								state_q <= ST_EMIT;
							end else begin
								empty_q <= 1'b0;
								state_q <= ST_DIV;
							end
						end else begin
							sum_q   <= sum_next;
							count_q <= count_next;
							pos_q   <= pos_next[LEN_W-1:0];
						end
					end
				end
				ST_DIV: begin
					rem_q    <= rem_next;
					div_sh_q <= {div_sh_q[QW-2:0], ge};
					cnt_q    <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						m_q     <= MUL_W'({div_sh_q[QW-2:0], ge});
						p_q     <= 5'd31;
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					// find the leading one, stopping at the integer bit
					if (p_q > 5'd16 && !m_q[MUL_W-1]) begin
						m_q <= {m_q[MUL_W-2:0], 1'b0};
						p_q <= p_q - 5'd1;
					end else begin
						cnt_q   <= CNT_W'(FRAC_W);
						frac_q  <= '0;
						state_q <= ST_SQ_MUL;
					end
				end
				ST_SQ_MUL: begin
					prod_q  <= mul_p;
					state_q <= ST_SQ_UPD;
				end
				ST_SQ_UPD: begin
					if (sq_t[MUL_W]) begin
						m_q    <= sq_t[MUL_W:1];
						frac_q <= {frac_q[FRAC_W-2:0], 1'b1};
					end else begin
						m_q    <= sq_t[MUL_W-1:0];
						frac_q <= {frac_q[FRAC_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1))
						state_q <= ST_MUL_K;
					else
						state_q <= ST_SQ_MUL;
				end
				ST_MUL_K: begin
					prod_q  <= mul_p;
					state_q <= ST_MUL_P;
				end
				ST_MUL_P: begin
					prod_q  <= mul_p;
					state_q <= ST_LEVEL;
				end
				ST_LEVEL: begin
					level_q <= lv_sat;
					// hold the running totals once the window count is full
					if (windows_q != '1) begin
						total_q   <= total_q + TW'(lv_sat);
						windows_q <= windows_q + RW'(1);
					end
					state_q <= ST_AVG_LOAD;
				end
				ST_AVG_LOAD: begin
					// average is below 2^12, so only twelve quotient bits are needed
					rem_q     <= avg_num[TW-1:LEVEL_W];
					div_sh_q  <= {avg_num[LEVEL_W-1:0], {(QW-LEVEL_W){1'b0}}};
					divisor_q <= windows_q;
					cnt_q     <= CNT_W'(LEVEL_W);
					state_q   <= ST_AVG_DIV;
				end
				ST_AVG_DIV: begin
					rem_q    <= rem_next;
					div_sh_q <= {div_sh_q[QW-2:0], ge};
					cnt_q    <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						avg_q   <= {div_sh_q[LEVEL_W-2:0], ge};
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						cur_out_q   <= level_q;
						avg_out_q   <= avg_q;
						used_out_q  <= used_q;
						no_signal_q <= empty_q;
						alert_q     <= !empty_q && (level_q > alert_level_q);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign current_level = cur_out_q;
	assign average_level = avg_out_q;
	assign samples_used  = used_out_q;
	assign no_signal     = no_signal_q;
	assign alert         = alert_q;

endmodule

@@ tb/sv/gated_sound_level_meter_top_test.sv @@
// Self-checking bench for the gated sound level meter: directed windows, stalls, random settings.
`timescale 1ns / 100ps

module gated_sound_level_meter_top_test;
	import gslm_pkg::*;

	localparam int SAMPLE_W       = SAMPLE_BITS_DEF;
	localparam int WINDOW_CNT_MAX = (1 << WINDOW_COUNT_BITS_DEF) - 1;
	localparam int IDLE_PCT       = 27;
	localparam int SETTLE_CYCLES  = 2 * SAMPLE_W + 140;
	localparam int HOLD_CYCLES    = 400;
	localparam int LIMIT_CYCLES   = 1_000_000;
	localparam int REPORT_MAX     = 10;
	localparam int RANDOM_ITEMS   = 500;
	localparam int RANDOM_WINDOWS = 48;

	typedef struct packed {
		logic [LEVEL_W-1:0] current_level;
		logic [LEVEL_W-1:0] average_level;
		logic [COUNT_W-1:0] samples_used;
		logic               no_signal;
		logic               alert;
	} window_result_t;

	typedef enum {MIX_PASS, MIX_BLOCK, MIX_EDGE, MIX_ANY} window_mix_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [SAMPLE_W-1:0]   sample = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [LEVEL_W-1:0]    current_level;
	logic [LEVEL_W-1:0]    average_level;
	logic [COUNT_W-1:0]    samples_used;
	logic                  no_signal;
	logic                  alert;
	logic                  cfg_we = 1'b0;
	cfg_addr_t             cfg_addr = REG_GATE_THRESHOLD;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// register copies
	logic [GATE_W-1:0]   gate_thr  = GATE_RESET;
	logic [LEN_W-1:0]    win_len   = LENGTH_RESET;
	logic [ALERT_W-1:0]  alert_lim = ALERT_RESET;
	logic [GAIN_W-1:0]   gain      = GAIN_RESET;
	logic [OFFSET_W-1:0] offset    = OFFSET_RESET;

	// window and running-average state
	logic [63:0]     gated_total = '0;
	int              gated_n = 0;
	int              win_pos = 0;
	longint unsigned level_sum = 0;
	int              windows_seen = 0;

	window_result_t pending_windows[$];

	bit steady = 1'b0;
	int hold_left = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	int cycle_count = 0;

	gated_sound_level_meter_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.current_level (current_level),
		.average_level (average_level),
		.samples_used  (samples_used),
		.no_signal     (no_signal),
		.alert         (alert),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("gated_sound_level_meter_top test failed");
			$finish;
		end
	end

	// log2 in Q.16 by repeated squaring of the normalized mantissa
	function automatic logic [31:0] log2_q16_fix(logic [31:0] q);
		int          p;
		logic [63:0] m;
		logic [15:0] frac;
		p = 31;
		while (p > 16 && !q[p])
			p--;
		m = (64'(q) << (31 - p)) & 64'hFFFF_FFFF;
		frac = '0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				frac[0] = 1'b1;
			end
		end
		return (32'(p - 16) << 16) | 32'(frac);
	endfunction

	function automatic logic [LEVEL_W-1:0] level_from_mean(logic [63:0] sum, int count);
		logic [63:0] q, ln32, prod, off, lv;
		q = (sum << 16) / count;
		if (q < 64'h1_0000)
			q = 64'h1_0000;
		if (q > 64'hFFFF_FFFF)
			q = 64'hFFFF_FFFF;
		ln32 = 64'(log2_q16_fix(q[31:0])) * 64'(LN2_Q16);
		prod = 64'(gain) * ln32;
		off = 64'(offset) << 32;
		if (prod <= off)
			return '0;
		lv = (prod - off + (64'd1 << 35)) >> 36;
		if (lv > 64'(LEVEL_MAX))
			lv = 64'(LEVEL_MAX);
		return lv[LEVEL_W-1:0];
	endfunction

	// gate one sample into the window; close the window when its length is reached
	function automatic void advance_window(logic [SAMPLE_W-1:0] s);
		window_result_t r;
		int             len;
		len = (win_len == 0) ? 1 : int'(win_len);
		if (s > gate_thr) begin
			gated_total += 64'(s);
			gated_n++;
		end
		win_pos++;
		if (win_pos < len)
			return;
		r.samples_used = gated_n[COUNT_W-1:0];
		r.no_signal = (gated_n == 0);
		r.current_level = '0;
		r.alert = 1'b0;
		if (gated_n != 0) begin
			r.current_level = level_from_mean(gated_total, gated_n);
			if (windows_seen < WINDOW_CNT_MAX) begin
				level_sum += r.current_level;
				windows_seen++;
			end
			r.alert = r.current_level > alert_lim;
		end
		if (windows_seen == 0)
			r.average_level = '0;
		else
			r.average_level = LEVEL_W'((level_sum + windows_seen / 2) / windows_seen);
		pending_windows.push_back(r);
		gated_total = '0;
		gated_n = 0;
		win_pos = 0;
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample(window_mix_t mix);
		int v;
		case (mix)
			MIX_PASS: begin
				if (gate_thr == {GATE_W{1'b1}})
					return {SAMPLE_W{1'b1}};
				return SAMPLE_W'($urandom_range({SAMPLE_W{1'b1}}, int'(gate_thr) + 1));
			end
			MIX_BLOCK: return SAMPLE_W'($urandom_range(int'(gate_thr), 0));
			MIX_EDGE: begin
				v = int'(gate_thr) + int'($urandom_range(2)) - 1;
				if (v < 0)
					v = 0;
				if (v > {SAMPLE_W{1'b1}})
					v = {SAMPLE_W{1'b1}};
				return SAMPLE_W'(v);
			end
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic write_reg(cfg_addr_t addr, logic [CFG_DATA_W-1:0] value);
		logic [CFG_DATA_W-1:0] mask, data;
		case (addr)
			REG_GATE_THRESHOLD: mask = CFG_DATA_W'((1 << GATE_W) - 1);
			REG_WINDOW_LENGTH:  mask = CFG_DATA_W'((1 << LEN_W) - 1);
			REG_ALERT_LEVEL:    mask = CFG_DATA_W'((1 << ALERT_W) - 1);
			REG_LOG_GAIN:       mask = CFG_DATA_W'((1 << GAIN_W) - 1);
			REG_LEVEL_OFFSET:   mask = CFG_DATA_W'((1 << OFFSET_W) - 1);
			default:            mask = '1;
		endcase
		// junk above the field width half of the time
		data = ($urandom_range(1) ? (CFG_DATA_W'($urandom) & ~mask) : '0) | (value & mask);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (addr)
			REG_GATE_THRESHOLD: gate_thr = data[GATE_W-1:0];
			REG_WINDOW_LENGTH:  win_len = data[LEN_W-1:0];
			REG_ALERT_LEVEL:    alert_lim = data[ALERT_W-1:0];
			REG_LOG_GAIN:       gain = data[GAIN_W-1:0];
			REG_LEVEL_OFFSET:   offset = data[OFFSET_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// called at a falling edge; leaves valid high after the transfer
	task automatic send_sample(logic [SAMPLE_W-1:0] s);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		advance_window(s);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic send_samples(int n, window_mix_t mix);
		for (int i = 0; i < n; i++)
			send_sample(pick_sample(mix));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_windows.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		window_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_windows.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: window result with none pending: level %0d avg %0d",
						$time, current_level, average_level);
			end else begin
				want = pending_windows.pop_front();
				results_seen++;
				if (current_level !== want.current_level ||
						average_level !== want.average_level ||
						samples_used !== want.samples_used ||
						no_signal !== want.no_signal || alert !== want.alert) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: window mismatch: expected level %0d avg %0d used %0d",
							$time, want.current_level, want.average_level, want.samples_used,
							" no_signal %0b alert %0b; got level %0d avg %0d used %0d",
							want.no_signal, want.alert, current_level, average_level,
							samples_used, " no_signal %0b alert %0b", no_signal, alert);
				end
			end
		end
	end

	task automatic test_default_settings();
		send_samples(int'(LENGTH_RESET), MIX_ANY);
		send_samples(int'(LENGTH_RESET), MIX_PASS);
	endtask

	task automatic test_gate_edges();
		wait_idle();
		write_reg(REG_WINDOW_LENGTH, 4);
		send_sample(SAMPLE_W'(GATE_RESET));
		send_sample(SAMPLE_W'(GATE_RESET) + 1'b1);
		send_sample({SAMPLE_W{1'b1}});
		send_sample('0);
	endtask

	task automatic test_level_extremes();
		wait_idle();
		write_reg(REG_GATE_THRESHOLD, 0);
		write_reg(REG_WINDOW_LENGTH, 1);
		send_sample({SAMPLE_W{1'b1}});
		send_sample(1);
		send_sample('0);
		wait_idle();
		write_reg(REG_LOG_GAIN, {GAIN_W{1'b1}});
		write_reg(REG_LEVEL_OFFSET, 0);
		write_reg(REG_ALERT_LEVEL, 0);
		send_sample({SAMPLE_W{1'b1}});
		send_sample(2);
		wait_idle();
		write_reg(REG_LEVEL_OFFSET, {OFFSET_W{1'b1}});
		write_reg(REG_ALERT_LEVEL, {ALERT_W{1'b1}});
		send_sample({SAMPLE_W{1'b1}});
		wait_idle();
		write_reg(REG_LOG_GAIN, 0);
		write_reg(REG_LEVEL_OFFSET, 0);
		send_sample({SAMPLE_W{1'b1}});
	endtask

	task automatic test_empty_window();
		wait_idle();
		write_reg(REG_LOG_GAIN, GAIN_RESET);
		write_reg(REG_LEVEL_OFFSET, OFFSET_RESET);
		write_reg(REG_ALERT_LEVEL, 0);
		write_reg(REG_GATE_THRESHOLD, {GATE_W{1'b1}});
		write_reg(REG_WINDOW_LENGTH, 3);
		send_sample({SAMPLE_W{1'b1}});
		send_sample('0);
		send_sample(SAMPLE_W'(1) << (SAMPLE_W - 1));
	endtask

	task automatic test_short_lengths();
		wait_idle();
		write_reg(REG_GATE_THRESHOLD, 100);
		write_reg(REG_WINDOW_LENGTH, 0);
		send_sample(3000);
		send_sample(50);
	endtask

	task automatic test_length_lowered();
		wait_idle();
		write_reg(REG_WINDOW_LENGTH, 10);
		send_samples(5, MIX_ANY);
		// shorten below the current position: the next sample closes the window
		wait_idle();
		write_reg(REG_WINDOW_LENGTH, 3);
		send_samples(1, MIX_PASS);
	endtask

	task automatic test_register_decode();
		wait_idle();
		write_reg(REG_GATE_THRESHOLD, 2000);
		write_reg(REG_WINDOW_LENGTH, 2);
		write_reg(REG_ALERT_LEVEL, ALERT_RESET);
		for (int a = int'(REG_LEVEL_OFFSET) + 1; a < (1 << CFG_ADDR_W); a++)
			write_reg(cfg_addr_t'(a), CFG_DATA_W'($urandom));
		send_sample(2500);
		send_sample(3500);
	endtask

	task automatic test_output_backpressure();
		wait_idle();
		write_reg(REG_GATE_THRESHOLD, 0);
		write_reg(REG_WINDOW_LENGTH, 2);
		// stall the output long enough to back up the input
		hold_left = HOLD_CYCLES;
		send_samples(60, MIX_ANY);
	endtask

	task automatic load_random_settings(int len);
		int r;
		r = $urandom_range(9);
		write_reg(REG_GATE_THRESHOLD, r == 0 ? 0 : r == 1 ? {GATE_W{1'b1}} :
			r < 6 ? $urandom_range(2000, 800) : $urandom);
		write_reg(REG_WINDOW_LENGTH, len);
		r = $urandom_range(9);
		write_reg(REG_ALERT_LEVEL, r == 0 ? 0 : r == 1 ? {ALERT_W{1'b1}} :
			r < 6 ? $urandom_range(2500, 200) : $urandom);
		r = $urandom_range(19);
		write_reg(REG_LOG_GAIN, r == 0 ? 0 : r < 3 ? {GAIN_W{1'b1}} :
			r < 6 ? $urandom :
			$urandom_range(int'(GAIN_RESET) + 8000, int'(GAIN_RESET) - 8000));
		r = $urandom_range(19);
		write_reg(REG_LEVEL_OFFSET, r == 0 ? 0 : r < 3 ? {OFFSET_W{1'b1}} :
			r < 7 ? $urandom :
			$urandom_range(int'(OFFSET_RESET) + 40000, int'(OFFSET_RESET) - 40000));
	endtask

	task automatic test_random_windows();
		int first_sent, first_seen, phase, len, n_win, r, big_left;
		first_sent = samples_sent;
		first_seen = results_seen;
		phase = 0;
		big_left = 1;
		while (samples_sent - first_sent < RANDOM_ITEMS ||
				results_seen - first_seen < RANDOM_WINDOWS) begin
			wait_idle();
			r = $urandom_range(99);
			if (r < 4 && big_left > 0) begin
				len = (1 << LEN_W) - 1;
				big_left--;
			end else if (r < 12)
				len = $urandom_range(1);
			else if (r < 72)
				len = $urandom_range(8, 2);
			else
				len = $urandom_range(40, 9);
			load_random_settings(len);
			// one phase with both sides running flat out
			steady = (phase == 3);
			n_win = steady ? 12 : (len == (1 << LEN_W) - 1) ? 1 : $urandom_range(4, 1);
			for (int w = 0; w < n_win; w++)
				send_samples(len == 0 ? 1 : len,
					len == (1 << LEN_W) - 1 ? MIX_PASS : window_mix_t'($urandom_range(3)));
			// leave a partial window for the next settings
			if (len > 1 && $urandom_range(3) == 0)
				send_samples($urandom_range(len - 1, 1), MIX_ANY);
			phase++;
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		test_default_settings();
		test_gate_edges();
		test_level_extremes();
		test_empty_window();
		test_short_lengths();
		test_length_lowered();
		test_register_decode();
		test_output_backpressure();
		test_random_windows();
		wait_idle();
		if (mismatches == 0 && pending_windows.size() == 0)
			$display("gated_sound_level_meter_top test passed");
		else
			$display("gated_sound_level_meter_top test failed");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/gslm_pkg.sv
hw/rtl/gated_sound_level_meter_top.sv
tb/sv/gated_sound_level_meter_top_test.sv
